// File: rtl/gcsp_pkg.sv
// Package for the glyph cache slot policy.
// Holds the fixed field widths, outcome and opcode codes and default sizes.
// No dependencies.
package gcsp_pkg;

    localparam int DIRECT_SLOTS_DEF = 128;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int HASHED_SLOTS     = 256;
    localparam int HASH_W           = 8;
    localparam int CODE_W           = 21;
    localparam int SLOT_INDEX_W     = 9;
    localparam int OUTCOME_W        = 3;

    typedef logic [OUTCOME_W-1:0] outcome_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam outcome_t OUT_HIT     = 3'd0;
    localparam outcome_t OUT_EMPTY   = 3'd1;
    localparam outcome_t OUT_FILLED  = 3'd2;
    localparam outcome_t OUT_KEPT    = 3'd3;
    localparam outcome_t OUT_EVICTED = 3'd4;
    localparam outcome_t OUT_FAILED  = 3'd5;
    localparam outcome_t OUT_CLEARED = 3'd6;

endpackage

// File: rtl/glyph_cache_slot_policy.sv
// Glyph cache slot policy: direct-mapped tag store with hit-count eviction.
// Uses gcsp_pkg for widths and codes; holds both memories itself.
//
// Usage
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   a lookup of code_point, or a clear of the whole cache (opcode). The
//   output channel (out_valid / out_stall) returns one result per request:
//   outcome, the slot examined and the resident hit count.
//   A lookup is one read-modify-write of the slot memory and the contention
//   memory, both with registered read data: the request and the read data are
//   registered as ST_LOOK is entered, and ST_LOOK loads the result register
//   once it is free; no new request is taken before then.
//   A clear walks all DIRECT_SLOTS + 256 slots (384 by default), one entry a
//   cycle, with the contention memory; ST_CDONE then registers the cleared
//   result once the result register is free. After reset the same walk runs
//   with in_stall high and gives no result; nothing else needs initialising.
//   When the receiver stalls, the result register holds its payload. One
//   further request can still be taken; its result waits in the read stage
//   until the result register frees up.
module glyph_cache_slot_policy
    import gcsp_pkg::*;
#(
    parameter int DIRECT_SLOTS = DIRECT_SLOTS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    opcode,
    input  logic [CODE_W-1:0]       code_point,
    input  logic                    fill_wanted,
    input  logic                    render_ok,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OUTCOME_W-1:0]    outcome,
    output logic [SLOT_INDEX_W-1:0] slot_index,
    output logic [COUNT_BITS-1:0]   hit_count
);

    localparam int TOTAL_SLOTS = DIRECT_SLOTS + HASHED_SLOTS;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam int ENTRY_W     = 1 + CODE_W + COUNT_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;
    localparam logic [1:0] ST_CDONE = 2'd3;

    // Memories
    logic [ENTRY_W-1:0]    slot_mem [TOTAL_SLOTS];
    logic [COUNT_BITS-1:0] cont_mem [HASHED_SLOTS];

    logic [1:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                  clr_op_reg, clr_op_next;

    // Request held through the read cycle
    logic [CODE_W-1:0]     cp_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic                  hashed_reg;
    logic                  fill_reg;
    logic                  ok_reg;

    logic [ENTRY_W-1:0]    slot_rd_reg;
    logic [COUNT_BITS-1:0] cont_rd_reg;

    logic                  out_valid_reg, out_valid_next;
    outcome_t              outcome_reg, outcome_next;
    logic [SLOT_W-1:0]     oslot_reg, oslot_next;
    logic [COUNT_BITS-1:0] ohits_reg, ohits_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  req_hashed;
    logic [HASH_W-1:0]     req_hash;
    logic [SLOT_W-1:0]     req_slot;

    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_waddr;
    logic [ENTRY_W-1:0]    slot_wdata;
    logic                  cont_we;
    logic [HASH_W-1:0]     cont_waddr;
    logic [COUNT_BITS-1:0] cont_wdata;

    logic                  rd_valid;
    logic [CODE_W-1:0]     rd_code;
    logic [COUNT_BITS-1:0] rd_hits;
    logic [COUNT_BITS-1:0] hits_inc;
    logic [COUNT_BITS-1:0] cont_inc;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // XOR fold of the code point bytes; the top byte is code_point[20:16] zero-extended
    assign req_hashed = (code_point >= CODE_W'(DIRECT_SLOTS));
    assign req_hash   = code_point[7:0] ^ code_point[15:8]
                      ^ {3'b000, code_point[20:16]};
    assign req_slot   = req_hashed ? (SLOT_W'(DIRECT_SLOTS) + SLOT_W'(req_hash))
                                   : code_point[SLOT_W-1:0];

    assign rd_valid = slot_rd_reg[ENTRY_W-1];
    assign rd_code  = slot_rd_reg[ENTRY_W-2 -: CODE_W];
    assign rd_hits  = slot_rd_reg[COUNT_BITS-1:0];
    assign hits_inc = (rd_hits == {COUNT_BITS{1'b1}}) ? rd_hits
                                                      : rd_hits + COUNT_BITS'(1);
    assign cont_inc = (cont_rd_reg == {COUNT_BITS{1'b1}}) ? cont_rd_reg
                                                          : cont_rd_reg + COUNT_BITS'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_op_next    = clr_op_reg;
        out_valid_next = out_valid_reg && out_stall;
        outcome_next   = outcome_reg;
        oslot_next     = oslot_reg;
        ohits_next     = ohits_reg;
        slot_we        = 1'b0;
        slot_waddr     = slot_reg;
        slot_wdata     = slot_rd_reg;
        cont_we        = 1'b0;
        cont_waddr     = hash_reg;
        cont_wdata     = cont_rd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (opcode == OP_CLEAR)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                        clr_op_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_LOOK:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    oslot_next     = slot_reg;
                    ohits_next     = rd_hits;
                    if (!rd_valid)
                    begin
                        ohits_next = '0;
                        if (fill_reg && ok_reg)
                        begin
                            slot_we      = 1'b1;
                            slot_wdata   = {1'b1, cp_reg, COUNT_BITS'(1)};
                            ohits_next   = COUNT_BITS'(1);
                            outcome_next = OUT_FILLED;
                        end
                        else
                        begin
                            outcome_next = fill_reg ? OUT_FAILED : OUT_EMPTY;
                        end
                    end
                    else if (rd_code == cp_reg)
                    begin
                        slot_we      = 1'b1;
                        slot_wdata   = {1'b1, cp_reg, hits_inc};
                        ohits_next   = hits_inc;
                        outcome_next = OUT_HIT;
                    end
                    else if (fill_reg && hashed_reg)
                    begin
                        cont_we = 1'b1;
                        if (cont_inc > rd_hits)
                        begin
                            // contention has outgrown the resident entry: evict
                            cont_wdata   = '0;
                            slot_we      = 1'b1;
                            slot_wdata   = {1'b0, rd_code, rd_hits};
                            ohits_next   = '0;
                            outcome_next = OUT_EVICTED;
                        end
                        else
                        begin
                            cont_wdata   = cont_inc;
                            outcome_next = OUT_KEPT;
                        end
                    end
                    else
                    begin
                        outcome_next = OUT_KEPT;
                    end
                end
            end

            ST_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_cnt_reg;
                slot_wdata = '0;
                cont_we    = (clr_cnt_reg < SLOT_W'(HASHED_SLOTS));
                cont_waddr = clr_cnt_reg[HASH_W-1:0];
                cont_wdata = '0;
                if (clr_cnt_reg == SLOT_W'(TOTAL_SLOTS - 1))
                begin
                    state_next = clr_op_reg ? ST_CDONE : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                end
            end

            ST_CDONE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    clr_op_next    = 1'b0;
                    out_valid_next = 1'b1;
                    outcome_next   = OUT_CLEARED;
                    oslot_next     = '0;
                    ohits_next     = '0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_op_reg    <= clr_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        oslot_reg   <= oslot_next;
        ohits_reg   <= ohits_next;
        if (in_xfer)
        begin
            cp_reg     <= code_point;
            slot_reg   <= req_slot;
            hash_reg   <= req_hash;
            hashed_reg <= req_hashed;
            fill_reg   <= fill_wanted;
            ok_reg     <= render_ok;
        end
    end

    // Slot memory: one read, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            slot_rd_reg <= slot_mem[req_slot];
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

    // Contention memory, indexed by hash
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cont_rd_reg <= cont_mem[req_hash];
        end
        if (cont_we)
        begin
            cont_mem[cont_waddr] <= cont_wdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign outcome    = outcome_reg;
    assign slot_index = oslot_reg[SLOT_INDEX_W-1:0];
    assign hit_count  = ohits_reg;

    // Assertions
    a_look_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("lookup did not deliver a result");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOOK || state_reg == ST_CLEAR))
        else $error("accepted request did not start work");

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (clr_cnt_reg <= SLOT_W'(TOTAL_SLOTS - 1)))
        else $error("clear walk ran past the slot memory");

    a_empty_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (outcome_reg == OUT_EMPTY || outcome_reg == OUT_FAILED
            || outcome_reg == OUT_EVICTED || outcome_reg == OUT_CLEARED))
        |-> (ohits_reg == '0))
        else $error("empty slot reported a hit count");

    a_fill_starts_at_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && outcome_reg == OUT_FILLED) |-> (ohits_reg == COUNT_BITS'(1)))
        else $error("fresh entry did not start at one hit");

endmodule
